FILE: design/ebc_pkg.sv
// Shared constants and types for the escape byte codec.
`default_nettype none

package ebc_pkg;

  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChCaret      = 8'h5E;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChReturn     = 8'h0D;
  localparam logic [7:0] ChNul        = 8'h00;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChLetterN    = 8'h6E;
  localparam logic [7:0] ChLetterR    = 8'h72;
  localparam logic [7:0] ChDigit0     = 8'h30;
  // 'A' - 1: caret encoding adds it, caret decoding subtracts it
  localparam logic [7:0] CtrlOffset   = 8'h40;
  localparam logic [7:0] CtrlLimit    = 8'h20;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Result of mapping one input byte: zero to two beats plus next flags.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first;
    logic [7:0] second;
    logic       esc;
    logic       ctl;
  } ebc_map_t;

endpackage

`default_nettype wire

FILE: design/ebc_mapper.sv
// Combinational encode/decode of one byte into up to two result beats.
`default_nettype none

module ebc_mapper
  import ebc_pkg::*;
(
  input  logic       mode_i,
  input  logic [7:0] byte_i,
  input  logic       esc_i,
  input  logic       ctl_i,
  output ebc_map_t   map_o
);

  ebc_map_t enc;
  ebc_map_t dec;

  always_comb begin
    enc        = '0;
    enc.esc    = esc_i;
    enc.ctl    = ctl_i;
    enc.count  = 2'd2;
    enc.first  = ChBackslash;
    enc.second = byte_i;
    unique case (byte_i)
      ChSpace: begin
        enc.count = 2'd1;
        enc.first = ChUnderscore;
      end
      ChUnderscore, ChBackslash, ChCaret: begin
        enc.second = byte_i;
      end
      ChNewline: enc.second = ChLetterN;
      ChReturn:  enc.second = ChLetterR;
      ChNul:     enc.second = ChDigit0;
      default: begin
        if (byte_i < CtrlLimit) begin
          enc.first  = ChCaret;
          enc.second = byte_i + CtrlOffset;
        end else begin
          enc.count = 2'd1;
          enc.first = byte_i;
        end
      end
    endcase
  end

  always_comb begin
    dec        = '0;
    dec.count  = 2'd1;
    dec.first  = byte_i;
    dec.second = byte_i;
    priority if (esc_i) begin
      priority if (byte_i == ChLetterN) dec.first = ChNewline;
      else if (byte_i == ChLetterR)     dec.first = ChReturn;
      else if (byte_i == ChDigit0)      dec.first = ChNul;
      else                              dec.first = byte_i;
    end else if (ctl_i) begin
      dec.first = byte_i - CtrlOffset;
    end else if (byte_i == ChUnderscore) begin
      dec.first = ChSpace;
    end else if (byte_i == ChBackslash) begin
      dec.count = 2'd0;
      dec.esc   = 1'b1;
    end else if (byte_i == ChCaret) begin
      dec.count = 2'd0;
      dec.ctl   = 1'b1;
    end else begin
      dec.first = byte_i;
    end
  end

  assign map_o = (mode_i == ModeDecode) ? dec : enc;

endmodule

`default_nettype wire

FILE: design/ebc_out_buf.sv
// Result register that sends zero, one or two beats per mapped item.
`default_nettype none

module ebc_out_buf
  import ebc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  ebc_map_t   map_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_item_o
);

  logic       valid_q, valid_d;
  logic       two_q, two_d;
  logic [7:0] cur_q, cur_d;
  logic [7:0] nxt_q, nxt_d;
  logic       fire;

  assign fire   = valid_q && !out_stall_i;
  assign free_o = !valid_q || (fire && !two_q);

  always_comb begin
    valid_d = valid_q;
    two_d   = two_q;
    cur_d   = cur_q;
    nxt_d   = nxt_q;
    if (load_i) begin
      valid_d = (map_i.count != 2'd0);
      two_d   = (map_i.count == 2'd2);
      cur_d   = map_i.first;
      nxt_d   = map_i.second;
    end else if (fire) begin
      // advance to the second beat, or drain
      if (two_q) begin
        cur_d = nxt_q;
        two_d = 1'b0;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      two_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      two_q   <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nxt_q <= nxt_d;
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = cur_q;
  assign last_of_item_o = !two_q;

endmodule

`default_nettype wire

FILE: design/escape_byte_codec.sv
// Top level of the backslash/caret escape byte codec.
`default_nettype none

// Byte-stream escape codec. cfg_data_i written with cfg_we_i selects the mode:
// 0 encodes (one or two result beats per input beat), 1 decodes (zero or one
// result beat; a backslash or caret opens a pending escape and sends nothing).
// An input beat is registered, mapped by one pass of combinational logic and
// loaded into a result register. A new input beat is taken every cycle while
// single-beat results drain without output stalls; a byte encoded to two beats
// stalls the input until its second beat goes out; decode runs at one beat per
// cycle without output stalls. end_of_string_i clears any pending escape after
// that byte. last_of_item_o marks the final result beat of each input beat.
module escape_byte_codec
  import ebc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_item_o
);

  logic       mode_q;
  logic       esc_q, esc_d;
  logic       ctl_q, ctl_d;
  logic       inv_q, inv_d;
  logic [7:0] byte_q;
  logic       eos_q;
  logic       accept;
  logic       load;
  logic       buf_free;
  ebc_map_t   map;

  assign load       = inv_q && buf_free;
  assign in_stall_o = inv_q && !buf_free;
  assign accept     = in_valid_i && !in_stall_o;

  ebc_mapper u_mapper (
    .mode_i (mode_q),
    .byte_i (byte_q),
    .esc_i  (esc_q),
    .ctl_i  (ctl_q),
    .map_o  (map)
  );

  always_comb begin
    inv_d = inv_q;
    if (accept) inv_d = 1'b1;
    else if (load) inv_d = 1'b0;
    esc_d = esc_q;
    ctl_d = ctl_q;
    if (load) begin
      // drop a dangling escape at end of string
      esc_d = map.esc && !eos_q;
      ctl_d = map.ctl && !eos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
      inv_q  <= 1'b0;
      esc_q  <= 1'b0;
      ctl_q  <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      inv_q <= inv_d;
      esc_q <= esc_d;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      eos_q  <= end_of_string_i;
    end
  end

  ebc_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .map_i          (map),
    .free_o         (buf_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

`default_nettype wire

FILE: tb/escape_byte_codec_tb.sv
// Self-checking testbench for the escape byte codec, covering encode and decode streams.
module escape_byte_codec_tb;
  import ebc_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        eos;
    int unsigned gap;
  } src_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_data_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_string_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_item_o;

  // Source bytes waiting to be sent, and converted bytes waiting to come out.
  src_beat_t   source_q[$];
  codec_beat_t converted_q[$];

  // Shadow copy of the codec mode and its pending decode flags.
  logic codec_mode = ModeEncode;
  logic escape_open = 1'b0;
  logic control_open = 1'b0;

  bit          tx_steady = 1'b0;
  int unsigned tx_idle = 0;
  src_beat_t   tx_next;
  int unsigned rx_hold = 0;
  int unsigned rx_beats = 0;
  int unsigned rx_inputs = 0;
  codec_beat_t rx_want;
  int unsigned errors = 0;

  logic [7:0] notable_bytes [16] = '{
    8'h00, 8'h01, 8'h0A, 8'h0D, 8'h1F, 8'h20, 8'h30, 8'h40,
    8'h41, 8'h5C, 8'h5E, 8'h5F, 8'h6E, 8'h72, 8'h7F, 8'hFF
  };

  escape_byte_codec u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_item_o  (last_of_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void emit(logic [7:0] data, logic last);
    converted_q.push_back(codec_beat_t'{data, last});
  endfunction

  // Work out the converted bytes that one source byte produces.
  function automatic void convert_byte(logic [7:0] c, logic eos);
    if (codec_mode == ModeEncode) begin
      case (c)
        ChSpace: emit(ChUnderscore, 1'b1);
        ChUnderscore, ChBackslash, ChCaret: begin
          emit(ChBackslash, 1'b0);
          emit(c, 1'b1);
        end
        ChNewline: begin
          emit(ChBackslash, 1'b0);
          emit(ChLetterN, 1'b1);
        end
        ChReturn: begin
          emit(ChBackslash, 1'b0);
          emit(ChLetterR, 1'b1);
        end
        ChNul: begin
          emit(ChBackslash, 1'b0);
          emit(ChDigit0, 1'b1);
        end
        default: begin
          if (c < CtrlLimit) begin
            emit(ChCaret, 1'b0);
            emit(c + CtrlOffset, 1'b1);
          end else begin
            emit(c, 1'b1);
          end
        end
      endcase
    end else if (escape_open) begin
      escape_open = 1'b0;
      case (c)
        ChLetterN: emit(ChNewline, 1'b1);
        ChLetterR: emit(ChReturn, 1'b1);
        ChDigit0:  emit(ChNul, 1'b1);
        default:   emit(c, 1'b1);
      endcase
    end else if (control_open) begin
      control_open = 1'b0;
      emit(c - CtrlOffset, 1'b1);
    end else if (c == ChUnderscore) begin
      emit(ChSpace, 1'b1);
    end else if (c == ChBackslash) begin
      escape_open = 1'b1;
    end else if (c == ChCaret) begin
      control_open = 1'b1;
    end else begin
      emit(c, 1'b1);
    end
    // flags survive a mode change but never an end of string
    if (eos) begin
      escape_open = 1'b0;
      control_open = 1'b0;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return notable_bytes[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic pick_eos();
    return $urandom_range(0, 11) == 0;
  endfunction

  task automatic send(logic [7:0] data, logic eos);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    source_q.push_back('{data: data, eos: eos, gap: gap});
  endtask

  task automatic write_mode(logic mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    codec_mode = mode;
  endtask

  // Hold until every byte is sent and every converted byte is back.
  task automatic settle();
    do @(posedge clk_i);
    while (source_q.size() != 0 || in_valid_i || converted_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned sent;
    int unsigned kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (codec_mode == ModeDecode && kind < 3) begin
        send(ChBackslash, pick_eos());
        send(pick_byte(), pick_eos());
        sent += 2;
      end else if (codec_mode == ModeDecode && kind < 6) begin
        send(ChCaret, pick_eos());
        if ($urandom_range(0, 3) != 0) send(8'(8'h40 + $urandom_range(0, 31)), pick_eos());
        else send(pick_byte(), pick_eos());
        sent += 2;
      end else begin
        send(pick_byte(), pick_eos());
        sent += 1;
      end
    end
  endtask

  // Source side: offer the next byte once its idle gap has passed.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) convert_byte(in_byte_i, end_of_string_i);
    if (!in_valid_i || !in_stall_o) begin
      if (source_q.size() != 0 && tx_idle >= source_q[0].gap) begin
        tx_next = source_q.pop_front();
        tx_idle = 0;
        in_valid_i <= 1'b1;
        in_byte_i <= tx_next.data;
        end_of_string_i <= tx_next.eos;
      end else begin
        in_valid_i <= 1'b0;
        if (source_q.size() != 0) tx_idle++;
      end
    end
  end

  // Result side: check each beat, stall at random, hold off long twice.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rx_inputs++;
      if (rx_inputs == 150 || rx_inputs == 450) rx_hold = 48;
    end
    if (out_valid_o && !out_stall_i) begin
      if (converted_q.size() == 0) begin
        $error("unexpected beat: out_byte %h last_of_item %b", out_byte_o, last_of_item_o);
        errors++;
      end else begin
        rx_want = converted_q.pop_front();
        if (out_byte_o !== rx_want.data) begin
          $error("out_byte: expected %h, got %h", rx_want.data, out_byte_o);
          errors++;
        end
        if (last_of_item_o !== rx_want.last) begin
          $error("last_of_item: expected %b, got %b", rx_want.last, last_of_item_o);
          errors++;
        end
      end
      rx_beats++;
      // every third stretch of 50 beats runs without stalls
      if (rx_hold == 0 && (rx_beats / 50) % 3 != 0) rx_hold = $urandom_range(0, 4);
    end
    out_stall_i <= (rx_hold != 0);
    if (rx_hold != 0) rx_hold--;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_steady = 1'b1;
    send(ChNul, 1'b0);
    send(ChNewline, 1'b0);
    send(ChReturn, 1'b0);
    send(8'h01, 1'b0);
    send(8'h1F, 1'b0);
    send(ChSpace, 1'b0);
    send(ChBackslash, 1'b0);
    send(ChCaret, 1'b0);
    send(ChUnderscore, 1'b0);
    send(8'h7F, 1'b0);
    send(8'hFF, 1'b1);
    settle();

    write_mode(ModeDecode);
    tx_steady = 1'b0;
    send(ChBackslash, 1'b0);
    send(ChLetterN, 1'b0);
    send(ChCaret, 1'b0);
    send(8'h40, 1'b0);
    send(ChCaret, 1'b0);
    send(8'hFF, 1'b0);
    send(ChUnderscore, 1'b0);
    // dangling escape and control at end of string: dropped
    send(ChBackslash, 1'b1);
    send(ChLetterN, 1'b0);
    send(ChCaret, 1'b1);
    send(8'h41, 1'b0);
    // leave an escape open across an encode stretch
    send(ChBackslash, 1'b0);
    settle();
    write_mode(ModeEncode);
    send(8'h41, 1'b0);
    settle();
    write_mode(ModeDecode);
    send(ChLetterR, 1'b1);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      tx_steady = (phase % 3 == 2);
      random_phase(100);
      settle();
      write_mode(phase % 2 == 0 ? ModeEncode : ModeDecode);
    end
    settle();

    if (errors == 0) begin
      $display("[escape_byte_codec] OK");
    end else begin
      $display("[escape_byte_codec] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[escape_byte_codec] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/ebc_pkg.sv
design/ebc_mapper.sv
design/ebc_out_buf.sv
design/escape_byte_codec.sv
tb/escape_byte_codec_tb.sv
